[sv/ntor_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ntor_pkg;

  // default geometry
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int KEY_BYTES_DEF     = 32;

  // field widths
  localparam int KEY_WORD_W = 64;
  localparam int TIME_W     = 32;
  localparam int PSNR_W     = 11;
  localparam int FSNR_W     = 8;
  localparam int SNR_W      = 8;
  localparam int SLOT_W     = 4;
  localparam int OUTCOME_W  = 2;
  localparam int COUNT_W    = 5;

  // saturation limits for the stored SNR
  localparam int SNR_MAX = 127;
  localparam int SNR_MIN = -128;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_MATCH = 2'd0,
    OUT_EMPTY = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch the input word, restart the scan
    logic issue;  // read one table entry
    logic write;  // write back the chosen slot, post the result
  } ntor_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_issue;  // scan pointer sits on the last entry
  } ntor_sts_t;

endpackage
`default_nettype wire

[sv/ntor_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module ntor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/ntor_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module ntor_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output ntor_pkg::ntor_cmd_t     cmd,
  input  wire ntor_pkg::ntor_sts_t sts
);
  import ntor_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN:  if (sts.last_issue) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd   = '0;
    busy  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN:  cmd.issue = 1'b1;
      ST_DRAIN: cmd = '0;
      ST_WRITE: cmd.write = 1'b1;
      default:  cmd = '0;
    endcase
  end

  // a taken word must make the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("start taken but block not busy");

  // the scan always ends in exactly one write-back
  a_drain_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> cmd.write)
    else $error("drain not followed by write-back");

  // write-back returns to idle
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> !busy)
    else $error("block still busy after write-back");

endmodule
`default_nettype wire

[sv/ntor_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module ntor_dp #(
  parameter int TABLE_ENTRIES = ntor_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BYTES     = ntor_pkg::KEY_BYTES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ntor_pkg::ntor_cmd_t                 cmd,
  output ntor_pkg::ntor_sts_t                      sts,
  input  wire logic [ntor_pkg::KEY_WORD_W-1:0]     key_word_0,
  input  wire logic [ntor_pkg::KEY_WORD_W-1:0]     key_word_1,
  input  wire logic [ntor_pkg::KEY_WORD_W-1:0]     key_word_2,
  input  wire logic [ntor_pkg::KEY_WORD_W-1:0]     key_word_3,
  input  wire logic [ntor_pkg::TIME_W-1:0]         advert_time,
  input  wire logic [ntor_pkg::TIME_W-1:0]         now_time,
  input  wire logic signed [ntor_pkg::PSNR_W-1:0]  packet_snr_quarters,
  input  wire logic signed [ntor_pkg::FSNR_W-1:0]  fallback_snr,
  output logic                                     res_valid,
  output logic [ntor_pkg::SLOT_W-1:0]              res_slot,
  output logic [ntor_pkg::OUTCOME_W-1:0]           res_outcome,
  output logic signed [ntor_pkg::SNR_W-1:0]        res_stored_snr,
  output logic [ntor_pkg::COUNT_W-1:0]             res_live_count
);
  import ntor_pkg::*;

  localparam int IW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW     = $clog2(TABLE_ENTRIES + 1);
  localparam int KW     = KEY_BYTES * 8;
  localparam int META_W = TIME_W + SNR_W + TIME_W;

  // full key as offered, word 0 in the low bits
  logic [4*KEY_WORD_W-1:0] key_cat;

  // latched input word
  logic [KW-1:0]            key_r;
  logic [TIME_W-1:0]        advert_r;
  logic [TIME_W-1:0]        now_r;
  logic signed [PSNR_W-1:0] psnr_r;
  logic signed [FSNR_W-1:0] fsnr_r;

  // scan state
  logic [IW-1:0]     ptr_r;
  logic [IW-1:0]     chk_idx_r;
  logic              chk_vld_r;
  logic              matched_r;
  logic [IW-1:0]     match_idx_r;
  logic              have_empty_r;
  logic [IW-1:0]     first_free_r;
  logic [TIME_W-1:0] oldest_ts_r;
  logic [IW-1:0]     stale_idx_r;

  // per-entry flags: written since reset, heard time nonzero
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] live_r;
  logic [CW-1:0]            count_r;

  logic [KW-1:0]     key_rd;
  logic [META_W-1:0] meta_rd;
  logic [TIME_W-1:0] heard_rd;
  logic              ent_valid;
  logic              ent_live;
  logic              key_eq;

  logic [IW-1:0]        slot_sel;
  outcome_t             outcome_sel;
  logic signed [SNR_W-1:0] snr_sel;
  logic [CW-1:0]        count_nxt;
  logic                 new_live;
  logic signed [FSNR_W+1:0] fb_x4;
  logic signed [SNR_W-1:0]  psat;
  logic signed [SNR_W-1:0]  fsat;
  logic [31:0]          slot_ext;
  logic [31:0]          count_ext;

  // table memories: keys, and heard/advert/snr per entry
  ntor_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (slot_sel),
    .wdata (key_r),
    .re    (cmd.issue),
    .raddr (ptr_r),
    .rdata (key_rd)
  );

  ntor_ram #(.WIDTH(META_W), .DEPTH(TABLE_ENTRIES)) u_meta_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (slot_sel),
    .wdata ({advert_r, snr_sel, now_r}),
    .re    (cmd.issue),
    .raddr (ptr_r),
    .rdata (meta_rd)
  );

  assign sts.last_issue = (ptr_r == IW'(TABLE_ENTRIES - 1));

  assign key_cat = {key_word_3, key_word_2, key_word_1, key_word_0};

  // entry under test; a never-written entry reads as all zero
  always_comb begin
    ent_valid = valid_r[chk_idx_r];
    ent_live  = live_r[chk_idx_r];
    heard_rd  = meta_rd[TIME_W-1:0];
    key_eq    = ent_valid ? (key_rd == key_r) : (key_r == '0);
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= key_cat[KW-1:0];
      advert_r <= advert_time;
      now_r    <= now_time;
      psnr_r   <= packet_snr_quarters;
      fsnr_r   <= fallback_snr;
    end
  end

  // scan pointer and compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      chk_vld_r    <= 1'b0;
      chk_idx_r    <= '0;
      matched_r    <= 1'b0;
      match_idx_r  <= '0;
      have_empty_r <= 1'b0;
      first_free_r <= '0;
      oldest_ts_r  <= '1;
      stale_idx_r  <= '0;
    end else begin
      chk_vld_r <= cmd.issue;
      chk_idx_r <= ptr_r;
      if (cmd.load) begin
        ptr_r        <= '0;
        matched_r    <= 1'b0;
        match_idx_r  <= '0;
        have_empty_r <= 1'b0;
        first_free_r <= '0;
        oldest_ts_r  <= '1;
        stale_idx_r  <= '0;
      end else begin
        if (cmd.issue) begin
          ptr_r <= ptr_r + IW'(1);
        end
        // first match stops the search
        if (chk_vld_r && !matched_r) begin
          if (key_eq) begin
            matched_r   <= 1'b1;
            match_idx_r <= chk_idx_r;
          end else if (!ent_live) begin
            if (!have_empty_r) begin
              have_empty_r <= 1'b1;
              first_free_r <= chk_idx_r;
            end
          end else if (heard_rd < oldest_ts_r) begin
            oldest_ts_r <= heard_rd;
            stale_idx_r <= chk_idx_r;
          end
        end
      end
    end
  end

  // slot choice and SNR saturation
  always_comb begin
    priority if (matched_r) begin
      slot_sel    = match_idx_r;
      outcome_sel = OUT_MATCH;
    end else if (have_empty_r) begin
      slot_sel    = first_free_r;
      outcome_sel = OUT_EMPTY;
    end else begin
      slot_sel    = stale_idx_r;
      outcome_sel = OUT_EVICT;
    end

    fb_x4 = {fsnr_r[FSNR_W-1], fsnr_r[FSNR_W-1], fsnr_r} <<< 2;

    if (psnr_r > PSNR_W'(SNR_MAX))      psat = SNR_W'(SNR_MAX);
    else if (psnr_r < PSNR_W'(SNR_MIN)) psat = SNR_W'(SNR_MIN);
    else                                psat = psnr_r[SNR_W-1:0];

    if (fb_x4 > (FSNR_W+2)'(SNR_MAX))      fsat = SNR_W'(SNR_MAX);
    else if (fb_x4 < (FSNR_W+2)'(SNR_MIN)) fsat = SNR_W'(SNR_MIN);
    else                                   fsat = fb_x4[SNR_W-1:0];

    snr_sel = ((psat == '0) && (fsnr_r != '0)) ? fsat : psat;

    // live count moves by the change at the written slot only
    new_live  = (now_r != '0);
    count_nxt = count_r + CW'(new_live) - CW'(live_r[slot_sel]);
    slot_ext  = 32'(slot_sel);
    count_ext = 32'(count_nxt);
  end

  // write-back of flags and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      live_r  <= '0;
      count_r <= '0;
    end else if (cmd.write) begin
      valid_r[slot_sel] <= 1'b1;
      live_r[slot_sel]  <= new_live;
      count_r           <= count_nxt;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.write;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      res_slot       <= slot_ext[SLOT_W-1:0];
      res_outcome    <= outcome_sel;
      res_stored_snr <= snr_sel;
      res_live_count <= count_ext[COUNT_W-1:0];
    end
  end

  // count can never pass the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES))
    else $error("live count above table size");

  // live flag of the written slot follows the heard time just stored
  a_live_follow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> (live_r[$past(slot_sel)] == ($past(now_r) != '0)))
    else $error("live flag not updated at written slot");

  // a live entry is always a written one
  a_live_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((live_r & ~valid_r) == '0))
    else $error("live flag on unwritten entry");

  // no scan read while a write-back is posted
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (!cmd.issue && !chk_vld_r))
    else $error("scan still running at write-back");

endmodule
`default_nettype wire

[sv/neighbor_table_oldest_replace_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake            Ports
// input     start & !busy        in_key_word_0..3, in_advert_time, in_now_time,
//                                in_packet_snr_quarters, in_fallback_snr
// result    out_valid (1 cycle)  out_slot, out_outcome, out_stored_snr, out_live_count
//
// A word passes through load, a scan of the table, drain and write-back: the table
// memory has one read port and is scanned one entry per cycle. The result strobes on
// the cycle after write-back; a new start is taken in that same cycle. Reset clears
// the written/live flags and count at once, so no clearing pass runs. The receiver
// cannot stall.
module neighbor_table_oldest_replace_unit #(
  parameter int TABLE_ENTRIES = ntor_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BYTES     = ntor_pkg::KEY_BYTES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ntor_pkg::KEY_WORD_W-1:0]     in_key_word_0,
  input  wire logic [ntor_pkg::KEY_WORD_W-1:0]     in_key_word_1,
  input  wire logic [ntor_pkg::KEY_WORD_W-1:0]     in_key_word_2,
  input  wire logic [ntor_pkg::KEY_WORD_W-1:0]     in_key_word_3,
  input  wire logic [ntor_pkg::TIME_W-1:0]         in_advert_time,
  input  wire logic [ntor_pkg::TIME_W-1:0]         in_now_time,
  input  wire logic signed [ntor_pkg::PSNR_W-1:0]  in_packet_snr_quarters,
  input  wire logic signed [ntor_pkg::FSNR_W-1:0]  in_fallback_snr,
  output logic                                     out_valid,
  output logic [ntor_pkg::SLOT_W-1:0]              out_slot,
  output logic [ntor_pkg::OUTCOME_W-1:0]           out_outcome,
  output logic signed [ntor_pkg::SNR_W-1:0]        out_stored_snr,
  output logic [ntor_pkg::COUNT_W-1:0]             out_live_count
);
  import ntor_pkg::*;

  ntor_cmd_t cmd;
  ntor_sts_t sts;

  ntor_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  ntor_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BYTES     (KEY_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .key_word_0          (in_key_word_0),
    .key_word_1          (in_key_word_1),
    .key_word_2          (in_key_word_2),
    .key_word_3          (in_key_word_3),
    .advert_time         (in_advert_time),
    .now_time            (in_now_time),
    .packet_snr_quarters (in_packet_snr_quarters),
    .fallback_snr        (in_fallback_snr),
    .res_valid           (out_valid),
    .res_slot            (out_slot),
    .res_outcome         (out_outcome),
    .res_stored_snr      (out_stored_snr),
    .res_live_count      (out_live_count)
  );

endmodule
`default_nettype wire
